// ===== rtl/tdpt_pkg.sv =====
// Shared constants and types for the trial division primality test core.
package tdpt_pkg;

  localparam int unsigned DataWidthDef = 32;

  // Divisor sequence constants: 3 is tried once, then 5, 7, 11, 13, ...
  localparam int unsigned DivisorThree = 3;
  localparam int unsigned DivisorFirst = 5;
  localparam int unsigned DivisorGap   = 2;
  localparam int unsigned DivisorStep  = 6;

  // Status that the divider returns to the sequencer.
  typedef struct packed {
    logic done;         // one-cycle pulse, quotient and remainder are final
    logic rem_zero;     // remainder is zero
    logic quot_ge_div;  // quotient is at least the divisor
  } div_stat_t;

endpackage

// ===== rtl/tdpt_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module tdpt_div
  import tdpt_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DATA_WIDTH-1:0] dividend_i,
  input  logic [DATA_WIDTH-1:0] divisor_i,
  output div_stat_t             stat_o
);

  localparam int unsigned CntW = $clog2(DATA_WIDTH);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] dvd_q, dvd_d;
  logic [DATA_WIDTH-1:0] dsr_q, dsr_d;
  logic [DATA_WIDTH:0]   trial;
  logic                  fits;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  assign trial = {rem_q, dvd_q[DATA_WIDTH-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = DATA_WIDTH'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[DATA_WIDTH-1:0];
      end
      dvd_d = {dvd_q[DATA_WIDTH-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DATA_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.done        = done_q;
  assign stat_o.rem_zero    = (rem_q == '0);
  assign stat_o.quot_ge_div = (dvd_q >= dsr_q);

`ifndef SYNTH
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && busy_q))
    else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done held longer than one cycle");
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < dsr_q))
    else $error("final remainder not below divisor");
`endif

endmodule

// ===== rtl/trial_division_primality_test_core.sv =====
// Primality test by trial division with divisors 3 and 6k-1, 6k+1.
//
//  channel  direction  payload (lowest bit up)
//  s_axis   in         tdata: value (DATA_WIDTH, signed), zero pad to bytes
//  m_axis   out        tdata: is_prime (1), zero pad to 8 bits
//
// Each trial divisor costs one pass of the bit-serial divider. Negative values,
// 0..3 and even values are answered without a divider pass. One item is worked
// on at a time; a new item is taken while the previous result waits on m_axis.
// Reset clears the control state; a stalled result holds until taken.
module trial_division_primality_test_core
  import tdpt_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]  s_axis_tdata,   // value
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata    // is_prime
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv3 = 3'd1;
  localparam logic [2:0] StDivA = 3'd2;
  localparam logic [2:0] StDivB = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [DATA_WIDTH-1:0] n_q, n_d;
  logic [DATA_WIDTH-1:0] d_q, d_d;
  logic                  res_q, res_d;
  logic                  ovalid_q, ovalid_d;
  logic                  oprime_q, oprime_d;
  logic                  accept;
  logic                  div_start;
  logic [DATA_WIDTH-1:0] div_divisor;
  logic [DATA_WIDTH-1:0] div_dividend;
  logic [DATA_WIDTH-1:0] in_value;
  div_stat_t             stat;

  assign in_value      = s_axis_tdata[DATA_WIDTH-1:0];
  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // The first pass starts at the accepting edge, before n_q holds the new value.
  assign div_dividend  = (state_q == StIdle) ? in_value : n_q;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    d_d         = d_q;
    res_d       = res_q;
    ovalid_d    = ovalid_q;
    oprime_d    = oprime_q;
    div_start   = 1'b0;
    div_divisor = DATA_WIDTH'(DivisorThree);
    if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          n_d = in_value;
          if (in_value[DATA_WIDTH-1]) begin
            res_d   = 1'b0;
            state_d = StFin;
          end else if (in_value <= DATA_WIDTH'(DivisorThree)) begin
            res_d   = (in_value > DATA_WIDTH'(1));
            state_d = StFin;
          end else if (!in_value[0]) begin
            res_d   = 1'b0;
            state_d = StFin;
          end else begin
            div_start = 1'b1;
            state_d   = StDiv3;
          end
        end
      end
      StDiv3: begin
        if (stat.done) begin
          if (stat.rem_zero) begin
            res_d   = 1'b0;
            state_d = StFin;
          end else begin
            d_d         = DATA_WIDTH'(DivisorFirst);
            div_divisor = DATA_WIDTH'(DivisorFirst);
            div_start   = 1'b1;
            state_d     = StDivA;
          end
        end
      end
      StDivA: begin
        // The quotient n / d doubles as the bound test d <= n / d.
        if (stat.done) begin
          if (!stat.quot_ge_div) begin
            res_d   = 1'b1;
            state_d = StFin;
          end else if (stat.rem_zero) begin
            res_d   = 1'b0;
            state_d = StFin;
          end else begin
            div_divisor = d_q + DATA_WIDTH'(DivisorGap);
            div_start   = 1'b1;
            state_d     = StDivB;
          end
        end
      end
      StDivB: begin
        if (stat.done) begin
          if (stat.rem_zero) begin
            res_d   = 1'b0;
            state_d = StFin;
          end else begin
            d_d         = d_q + DATA_WIDTH'(DivisorStep);
            div_divisor = d_q + DATA_WIDTH'(DivisorStep);
            div_start   = 1'b1;
            state_d     = StDivA;
          end
        end
      end
      StFin: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          oprime_d = res_q;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    d_q      <= d_d;
    res_q    <= res_d;
    oprime_q <= oprime_d;
  end

  tdpt_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (stat)
  );

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'd0, oprime_q};

`ifndef SYNTH
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> (state_q == StDiv3 || state_q == StDivA || state_q == StDivB))
    else $error("divider finished outside a divide state");
  a_bound_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivA && stat.done && !stat.quot_ge_div) |=> (state_q == StFin && res_q))
    else $error("passing the square bound did not report prime");
  a_odd_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivA || state_q == StDivB) |-> d_q[0])
    else $error("trial divisor is even");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the trial division primality test core.
`timescale 1ns / 1ps

module tb;
  import tdpt_pkg::*;

  localparam int unsigned DW          = DataWidthDef;
  localparam int unsigned TDATA_W     = ((DW + 7) / 8) * 8;
  localparam int unsigned RANDOM_ITEMS = 80;
  // The largest 32-bit prime dominates the cycle budget; the rest of the run is small.
  localparam longint unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_CHOPPY,
    RX_SPARSE
  } rx_mode_e;

  // Keeps the verdicts owed by the core, oldest first, and checks each result against them.
  class primality_scoreboard;
    bit          verdict_q[$];
    int unsigned mismatches;
    int unsigned values_taken;
    int unsigned verdicts_checked;
    int unsigned primes_seen;
    int unsigned negatives_seen;

    // Trial division over 6k-1 and 6k+1, with an exact bound test on 64-bit values.
    function automatic bit prime_verdict(logic [DW-1:0] raw);
      longint unsigned n;
      longint unsigned d;
      if (raw[DW-1]) begin
        return 1'b0;
      end
      n = longint'(raw);
      if (n <= 3) begin
        return n > 1;
      end
      if ((n % 2) == 0 || (n % 3) == 0) begin
        return 1'b0;
      end
      for (d = 5; d <= n / d; d += 6) begin
        if ((n % d) == 0 || (n % (d + 2)) == 0) begin
          return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void note_value(logic [DW-1:0] value);
      bit verdict;
      verdict = prime_verdict(value);
      verdict_q.push_back(verdict);
      values_taken++;
      if (value[DW-1]) begin
        negatives_seen++;
      end
      if (verdict) begin
        primes_seen++;
      end
    endfunction

    function void check_verdict(logic [7:0] tdata);
      logic [7:0] want;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("tb: result 0x%02h arrived with no value outstanding", tdata);
        end
        return;
      end
      want = {7'b0, verdict_q.pop_front()};
      verdicts_checked++;
      if (tdata !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("tb: result %0d is_prime mismatch: expected 0x%02h, got 0x%02h",
                   verdicts_checked, want, tdata);
        end
      end
    endfunction

    function int unsigned outstanding();
      return verdict_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata  = '0;   // value
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [7:0]         m_axis_tdata;         // is_prime, zero padded

  primality_scoreboard verdicts = new();

  longint unsigned cycle_count = 0;
  rx_mode_e        rx_mode     = RX_OPEN;
  int unsigned     rx_phase_left = 0;

  trial_division_primality_test_core #(
    .DATA_WIDTH(DW)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d verdicts outstanding",
               cycle_count, verdicts.outstanding());
      $display("tb: FAIL");
      $finish;
    end
  end

  // Both handshakes are sampled at the rising edge, before the core updates its outputs.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      verdicts.note_value(s_axis_tdata[DW-1:0]);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      verdicts.check_verdict(m_axis_tdata);
    end
  end

  // The receiver switches between always ready, coin-flip and mostly stalled phases.
  always @(negedge clk_i) begin
    if (rx_phase_left == 0) begin
      rx_mode       <= rx_mode_e'($urandom_range(0, 2));
      rx_phase_left <= $urandom_range(16, 200);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
      default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_value(logic [DW-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(value);
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
  endtask

  task automatic hold_off(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= TDATA_W'($urandom);
    end
  endtask

  // Mostly small magnitudes keep the run short; large values come as negatives
  // or as multiples of a small factor so the divisor loop stops early.
  function automatic logic [DW-1:0] random_value();
    int unsigned pick;
    int unsigned factor;
    logic [DW-1:0] value;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      value = DW'($urandom) | (DW'(1) << (DW - 1));
    end else if (pick < 27) begin
      factor = $urandom_range(2, 211);
      value  = DW'(factor * $urandom_range(1, 32'h7FFF_FFFF / factor));
    end else if (pick < 32) begin
      value = DW'($urandom_range(0, 15));
    end else if (pick < 82) begin
      value = DW'($urandom_range(0, 16'hFFFF));
    end else begin
      value = DW'($urandom_range(0, 22'h3F_FFFF));
    end
    return value;
  endfunction

  initial begin
    logic [DW-1:0] directed_values[$];
    int unsigned   sent;
    int unsigned   burst;

    directed_values = '{
      32'h8000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
      0, 1, 2, 3, 4, 5, 6, 9, 25, 35, 49, 121, 143, 169, 63001, 65521,
      32'h5555_5555, 32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h7FFF_FFFF
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed items go back to back, so the sender never idles here.
    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
    end
    hold_off(1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && sent < RANDOM_ITEMS) begin
        send_value(random_value());
        burst--;
        sent++;
      end
      hold_off($urandom_range(1, 12));
    end

    while (verdicts.outstanding() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("tb: %0d values tested, %0d prime, %0d negative, %0d verdicts checked",
             verdicts.values_taken, verdicts.primes_seen, verdicts.negatives_seen,
             verdicts.verdicts_checked);
    $display("tb: directed edges, small and 22-bit values, large composites; %0d mismatches",
             verdicts.mismatches);
    if (verdicts.mismatches == 0 && verdicts.outstanding() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
